// ===== hdl/rsr_pkg.sv =====
// rsr_pkg: shared types for the record sort unit
// holds the input and result records and the controller/datapath command and status groups
// no dependencies
package rsr_pkg;

    localparam int RATING_W = 10;
    localparam int TAG_W    = 16;

    // one input record
    typedef struct packed {
        logic [RATING_W-1:0] rating;
        logic [TAG_W-1:0]    tag;
        logic                last_item;
    } t_in;

    // one sorted result record
    typedef struct packed {
        logic [RATING_W-1:0] sorted_rating;
        logic [TAG_W-1:0]    sorted_tag;
        logic                last_out;
    } t_out;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sort;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sort_done;
        logic last_one;
    } t_stat;

endpackage

// ===== hdl/record_sort_by_rating_unit.sv =====
// record_sort_by_rating_unit: top level of the record sort unit
// depends on rsr_pkg, rsr_ctrl and rsr_datapath
//
// usage:
//   input channel: a record (rating, tag, last_item) transfers at a rising edge
//   with start high and busy low. records are kept in load order; once DEPTH are
//   held, further records are dropped, though a dropped record with last_item
//   still closes the set.
//   a transfer with last_item set closes the set. busy then rises, the held set
//   is sorted by rating, highest first, equal ratings staying in load order.
//   sorting takes one odd-even transposition phase per cycle, as many phases as
//   records held, then the held results leave one per cycle.
//   result channel: o_valid strobes for one cycle with o_result; last_out marks
//   the final record. the receiver cannot stall; every strobe is a transfer.
//   busy falls as the last result is being registered, so the next set may
//   start loading while that result is on the port.
//   reset (i_rst_n low, synchronous) empties the store and clears busy.
module record_sort_by_rating_unit
    import rsr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    rsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_item (i_item.last_item),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    // store, sort network and result register
    rsr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_stat   (w_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// ===== hdl/rsr_datapath.sv =====
// rsr_datapath: record store, odd-even transposition sort and output register
// depends on rsr_pkg; driven by rsr_ctrl through t_cmd
module rsr_datapath
    import rsr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_item,
    output t_stat o_stat,
    output logic  o_valid,
    output t_out  o_result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [RATING_W-1:0] r_rating [DEPTH];
    logic [TAG_W-1:0]    r_tag    [DEPTH];
    logic [RATING_W-1:0] n_rating [DEPTH];
    logic [TAG_W-1:0]    n_tag    [DEPTH];
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_phase, n_phase;
    logic                r_out_valid;
    t_out                r_out;
    logic                w_full;

    assign w_full = (r_count == CW'(DEPTH));

    // status back to the controller
    assign o_stat.sort_done = (r_phase == r_count - CW'(1));
    assign o_stat.last_one  = (r_count == CW'(1));

    // next store contents: load, one sort phase, or shift toward entry zero
    always_comb begin
        n_rating = r_rating;
        n_tag    = r_tag;
        n_count  = r_count;
        n_phase  = r_phase;
        priority if (i_cmd.load) begin
            n_phase = '0;
            if (!w_full) begin
                n_rating[r_count[IW-1:0]] = i_item.rating;
                n_tag[r_count[IW-1:0]]    = i_item.tag;
                n_count                   = r_count + CW'(1);
            end
        end else if (i_cmd.sort) begin
            n_phase = r_phase + CW'(1);
            // pairs of this parity are disjoint; strict compare keeps equal ratings in order
            for (int i = 0; i < DEPTH - 1; i++) begin
                if ((1'(i) == r_phase[0]) && (CW'(i + 1) < r_count)
                        && (r_rating[i] < r_rating[i+1])) begin
                    n_rating[i]   = r_rating[i+1];
                    n_tag[i]      = r_tag[i+1];
                    n_rating[i+1] = r_rating[i];
                    n_tag[i+1]    = r_tag[i];
                end
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_rating[i] = r_rating[i+1];
                n_tag[i]    = r_tag[i+1];
            end
            n_count = r_count - CW'(1);
        end
    end

    // record store, no reset
    always_ff @(posedge i_clk) begin
        r_rating <= n_rating;
        r_tag    <= n_tag;
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= '0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    // result payload from the head of the store
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.sorted_rating <= r_rating[0];
            r_out.sorted_tag    <= r_tag[0];
            r_out.last_out      <= (r_count == CW'(1));
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // store never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("record count beyond depth");

    // emission only with records held
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_count != '0)
        else $error("emit with empty store");

    // final result leaves the store empty
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_out) |-> r_count == '0)
        else $error("store not empty after final result");

    // sorting never runs past the held count
    a_sort_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sort |-> r_phase < r_count)
        else $error("sort phase beyond record count");

endmodule

// ===== hdl/rsr_ctrl.sv =====
// rsr_ctrl: load / sort / emit sequencer for the record sort unit
// depends on rsr_pkg; commands rsr_datapath through t_cmd
module rsr_ctrl
    import rsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_last_item,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_SORT = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.sort = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_item) n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                o_cmd.sort = 1'b1;
                if (i_stat.sort_done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_stat.last_one) n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_LOAD);

    // only one datapath command at a time
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.sort, o_cmd.emit}))
        else $error("conflicting datapath commands");

    // a closing transfer always starts a sort
    a_close_sorts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_last_item) |=> o_cmd.sort)
        else $error("closing record did not start sort");

    // sort finish hands over to emission
    a_sort_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.sort && i_stat.sort_done) |=> o_cmd.emit)
        else $error("sort end did not start emission");

endmodule

// ===== tb/record_sort_by_rating_unit_tb.sv =====
// record_sort_by_rating_unit_tb: self-checking testbench for the record sort unit
// predicts each sorted set in the testbench and checks every result strobe in order
// depends on rsr_pkg and record_sort_by_rating_unit
module record_sort_by_rating_unit_tb;
    import rsr_pkg::*;

    localparam int DEPTH      = 64;
    localparam int HALF_CLK   = 6;
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_ITEMS = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_valid;
    t_out o_result;

    // predicted contents of the store
    logic [RATING_W-1:0] held_rating [DEPTH];
    logic [TAG_W-1:0]    held_tag    [DEPTH];
    int                  held_count;

    // sorted records still owed by the block
    t_out sorted_q [$];

    int  taken_count;
    int  err_count;
    int  cycle_count;
    int  burst_left;
    bit  gaps_on;

    record_sort_by_rating_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // clock, starting low so the first rising edge comes after time zero
    always begin
        #HALF_CLK;
        i_clk = 1'b1;
        #HALF_CLK;
        i_clk = 1'b0;
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("record_sort_by_rating_unit regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // store one accepted record; on a closing record sort the set and queue it
    task automatic take_record(input t_in rec);
        logic [RATING_W-1:0] r;
        logic [TAG_W-1:0]    t;
        t_out                res;
        int                  j;
        if (held_count < DEPTH) begin
            held_rating[held_count] = rec.rating;
            held_tag[held_count]    = rec.tag;
            held_count++;
        end
        if (rec.last_item) begin
            // stable descending insertion: move up only past a strictly smaller rating
            for (int i = 1; i < held_count; i++) begin
                j = i;
                while (j > 0 && held_rating[j-1] < held_rating[j]) begin
                    r = held_rating[j-1];
                    t = held_tag[j-1];
                    held_rating[j-1] = held_rating[j];
                    held_tag[j-1]    = held_tag[j];
                    held_rating[j]   = r;
                    held_tag[j]      = t;
                    j--;
                end
            end
            for (int k = 0; k < held_count; k++) begin
                res.sorted_rating = held_rating[k];
                res.sorted_tag    = held_tag[k];
                res.last_out      = (k == held_count - 1);
                sorted_q.push_back(res);
            end
            held_count = 0;
        end
    endtask

    // check results, then predict from any input transfer at this edge
    always @(posedge i_clk) begin : check_and_predict
        t_out want;
        if (i_rst_n && o_valid) begin
            if (sorted_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result rating %0d tag %h last %0d",
                    o_result.sorted_rating, o_result.sorted_tag, o_result.last_out));
            end else begin
                want = sorted_q.pop_front();
                if (o_result.sorted_rating !== want.sorted_rating)
                    report_mismatch($sformatf("sorted_rating %0d, expected %0d",
                        o_result.sorted_rating, want.sorted_rating));
                if (o_result.sorted_tag !== want.sorted_tag)
                    report_mismatch($sformatf("sorted_tag %h, expected %h",
                        o_result.sorted_tag, want.sorted_tag));
                if (o_result.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out %0d, expected %0d",
                        o_result.last_out, want.last_out));
            end
        end
        if (i_rst_n && start && !busy) begin
            take_record(i_item);
            taken_count++;
        end
    end

    // send one record; entered and left at a falling edge
    task automatic send_record(input logic [RATING_W-1:0] rating,
                               input logic [TAG_W-1:0] tag, input logic last_item);
        int id;
        if (gaps_on && burst_left == 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        i_item.rating    = rating;
        i_item.tag       = tag;
        i_item.last_item = last_item;
        start = 1'b1;
        id = taken_count;
        do @(negedge i_clk); while (taken_count == id);
        if (burst_left > 0)
            burst_left--;
    endtask

    // hold off until every owed result has come
    task automatic wait_drained();
        start = 1'b0;
        while (sorted_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // one-record sets at the field extremes
    task automatic test_single_records();
        send_record(10'h3FF, 16'hFFFF, 1'b1);
        send_record(10'h000, 16'h0000, 1'b1);
        wait_drained();
    endtask

    // mixed order, ties that must keep load order, reversed and all-equal sets
    task automatic test_order_and_ties();
        send_record(10'd100,  16'h0001, 1'b0);
        send_record(10'd1000, 16'h0002, 1'b0);
        send_record(10'd500,  16'h0003, 1'b0);
        send_record(10'd1000, 16'h0004, 1'b0);
        send_record(10'd100,  16'h0005, 1'b1);
        send_record(10'd0,    16'hA5A5, 1'b0);
        send_record(10'd1,    16'h5A5A, 1'b0);
        send_record(10'd2,    16'hF0F0, 1'b0);
        send_record(10'd1023, 16'h0F0F, 1'b1);
        for (int i = 0; i < 4; i++)
            send_record(10'd777, 16'(16'h1000 + i), (i == 3));
        wait_drained();
    endtask

    // fill the store, then overflow it with the closing record dropped
    task automatic test_store_full();
        gaps_on = 1'b0;
        for (int i = 0; i < DEPTH + 2; i++)
            send_record(10'($urandom_range(0, 7) * 146), 16'($urandom), (i == DEPTH + 1));
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // random well-formed sets, mostly small, with a pause midway
    task automatic test_random_sets();
        int sent;
        int set_len;
        int mode;
        bit paused;
        logic [RATING_W-1:0] rating;
        sent   = 0;
        paused = 1'b0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: set_len = $urandom_range(9, 16);
                default:    set_len = $urandom_range(1, 8);
            endcase
            mode    = $urandom_range(0, 2);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < set_len; i++) begin
                case (mode)
                    0:       rating = 10'($urandom_range(0, 3) * 341);
                    1:       rating = 10'($urandom_range(100, 1000));
                    default: rating = 10'($urandom_range(0, 1023));
                endcase
                send_record(rating, 16'($urandom), (i == set_len - 1));
                sent++;
            end
            if (!paused && sent >= RAND_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        held_count  = 0;
        taken_count = 0;
        err_count   = 0;
        cycle_count = 0;
        burst_left  = 0;
        gaps_on     = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_single_records();
        test_order_and_ties();
        test_store_full();
        test_random_sets();

        // let any stray strobe show up before the verdict
        wait_drained();
        repeat (2 * DEPTH + 8) @(negedge i_clk);
        if (sorted_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", sorted_q.size()));
        if (err_count == 0) begin
            $display("record_sort_by_rating_unit regression: pass");
        end else begin
            $display("record_sort_by_rating_unit regression: fail");
        end
        $finish;
    end

endmodule
